[rtl/gbg_pkg.sv]
// ============================================================================
// gbg_pkg: shared types and constants for the gyro bias estimator
// Field widths, queue entry layout, config register indexes and resets.
// ============================================================================
package gbg_pkg;

    localparam int SAMPLES_PER_UPDATE_DEF = 8;

    localparam int IN_W      = 16;   // accel, matrix row and interval width
    localparam int AVG_W     = 18;   // averaged accel, always within +/-2^17
    localparam int BIAS_W    = 32;   // Q16.16 bias
    localparam int Q_DEPTH   = 2;    // front-to-back queue depth

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_RATE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] BIAS_GAIN_RST  = 16'd655;
    localparam logic [CFG_DATA_W-1:0] LIMIT_RATE_RST = 16'd1331;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] bias_gain;
        logic [CFG_DATA_W-1:0] limit_rate;
    } t_cfg;

    // One classified item: update flag plus everything the back end needs
    typedef struct packed {
        logic                     upd;
        logic signed [AVG_W-1:0]  ax;
        logic signed [AVG_W-1:0]  ay;
        logic signed [AVG_W-1:0]  az;
        logic signed [IN_W-1:0]   rx;
        logic signed [IN_W-1:0]   ry;
        logic signed [IN_W-1:0]   rz;
        logic [IN_W-1:0]          dt;
    } t_qent;

endpackage

[rtl/gbg_in_if.sv]
// ============================================================================
// gbg_in_if: sample channel
// Valid/ready channel carrying one accelerometer sample, matrix row, interval.
// ============================================================================
interface gbg_in_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic [15:0] interval;

    modport source (
        output valid, accel_x, accel_y, accel_z, rot_x, rot_y, rot_z, interval,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, rot_x, rot_y, rot_z, interval,
        output ready
    );
endinterface

[rtl/gbg_out_if.sv]
// ============================================================================
// gbg_out_if: bias result channel
// Valid/ready channel carrying the current X/Y bias and the update flag.
// ============================================================================
interface gbg_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] bias_x;
    logic signed [31:0] bias_y;
    logic        updated;

    modport source (output valid, bias_x, bias_y, updated, input ready);
    modport sink   (input  valid, bias_x, bias_y, updated, output ready);
endinterface

[rtl/gbg_front.sv]
// ============================================================================
// gbg_front: sample accumulator and classifier
// Sums accel samples, counts them, and pushes each item into the queue,
// tagged as an update item (with averaged accel) on every Nth sample.
// ============================================================================
module gbg_front #(
    parameter int SAMPLES_PER_UPDATE = gbg_pkg::SAMPLES_PER_UPDATE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    gbg_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_q_push,
    output gbg_pkg::t_qent  o_q_data
);
    localparam int SUM_W     = gbg_pkg::IN_W + $clog2(SAMPLES_PER_UPDATE);
    localparam int CNT_W     = $clog2(SAMPLES_PER_UPDATE + 1);
    localparam int AVG_SHIFT = $clog2(SAMPLES_PER_UPDATE + 1) - 1;   // floor(log2 N)

    logic signed [SUM_W-1:0] r_sum_x, r_sum_y, r_sum_z;
    logic signed [SUM_W-1:0] n_sum_x, n_sum_y, n_sum_z;
    logic [CNT_W-1:0]        r_cnt;
    logic                    accept;
    logic                    last;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign last       = (r_cnt == CNT_W'(SAMPLES_PER_UPDATE - 1));

    assign n_sum_x = r_sum_x + SUM_W'(i_in.accel_x);
    assign n_sum_y = r_sum_y + SUM_W'(i_in.accel_y);
    assign n_sum_z = r_sum_z + SUM_W'(i_in.accel_z);

    always_comb begin
        o_q_push     = accept;
        o_q_data.upd = last;
        o_q_data.ax  = gbg_pkg::AVG_W'(n_sum_x >>> AVG_SHIFT);
        o_q_data.ay  = gbg_pkg::AVG_W'(n_sum_y >>> AVG_SHIFT);
        o_q_data.az  = gbg_pkg::AVG_W'(n_sum_z >>> AVG_SHIFT);
        o_q_data.rx  = i_in.rot_x;
        o_q_data.ry  = i_in.rot_y;
        o_q_data.rz  = i_in.rot_z;
        o_q_data.dt  = i_in.interval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_cnt   <= '0;
        end else if (accept) begin
            if (last) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sum_z <= '0;
                r_cnt   <= '0;
            end else begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_sum_z <= n_sum_z;
                r_cnt   <= r_cnt + CNT_W'(1);
            end
        end
    end
endmodule

[rtl/gbg_queue.sv]
// ============================================================================
// gbg_queue: short item queue
// Register FIFO between the classifier and the bias update sequencer.
// ============================================================================
module gbg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gbg_pkg::t_qent  i_data,
    input  logic            i_pop,
    output gbg_pkg::t_qent  o_data,
    output logic            o_full,
    output logic            o_empty
);
    localparam int PTR_W = (gbg_pkg::Q_DEPTH > 1) ? $clog2(gbg_pkg::Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(gbg_pkg::Q_DEPTH + 1);

    gbg_pkg::t_qent   r_mem [gbg_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(gbg_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(gbg_pkg::Q_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(gbg_pkg::Q_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end
endmodule

[rtl/gbg_back.sv]
// ============================================================================
// gbg_back: bias update sequencer
// Runs the error, clamp and gain math on one shared registered multiplier,
// keeps the saturating X/Y biases and drives the output register.
// ============================================================================
module gbg_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbg_pkg::t_cfg   i_cfg,
    input  gbg_pkg::t_qent  i_q_data,
    input  logic            i_q_empty,
    output logic            o_q_pop,
    gbg_out_if.source       o_out
);
    localparam int MA_W  = 41;   // multiplier A operand (clamped term up to 40b)
    localparam int MB_W  = 17;   // multiplier B operand
    localparam int P_W   = MA_W + MB_W;
    localparam int E_W   = 35;   // error terms
    localparam int LIM_W = 38;   // limit_rate * interval << 6
    localparam int C_W   = 40;   // clamped term
    localparam int D_W   = 36;   // bias increment and sum

    typedef enum logic [3:0] {
        S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_DONE
    } t_state;

    t_state                         r_state;
    logic                           r_upd;
    logic signed [gbg_pkg::AVG_W-1:0] r_ax, r_ay, r_az;
    logic signed [gbg_pkg::IN_W-1:0]  r_rx, r_ry, r_rz;
    logic [gbg_pkg::IN_W-1:0]       r_dt;
    logic signed [P_W-1:0]          r_prod;
    logic signed [E_W-1:0]          r_acc, r_e0;
    logic [LIM_W-1:0]               r_lim;
    logic signed [C_W-1:0]          r_c0, r_c1;
    logic signed [gbg_pkg::BIAS_W-1:0] r_bias_x, r_bias_y;
    logic                           r_out_valid;
    logic signed [gbg_pkg::BIAS_W-1:0] r_out_x, r_out_y;
    logic                           r_out_upd;

    logic signed [MA_W-1:0]         mul_a;
    logic signed [MB_W-1:0]         mul_b;
    logic signed [MB_W-1:0]         dt_s, gain_s;

    function automatic logic signed [C_W-1:0] clamp(
        input logic signed [P_W-1:0] p,
        input logic [LIM_W-1:0]      lim
    );
        logic signed [P_W-1:0] l;
        l = $signed({{(P_W-LIM_W){1'b0}}, lim});
        if (p > l) begin
            clamp = C_W'(l);
        end else if (p < -l) begin
            clamp = C_W'(-l);
        end else begin
            clamp = C_W'(p);
        end
    endfunction

    // bias + floor(p / 2^22), saturated to 32 bits
    function automatic logic signed [gbg_pkg::BIAS_W-1:0] sat_add(
        input logic signed [gbg_pkg::BIAS_W-1:0] b,
        input logic signed [P_W-1:0]             p
    );
        logic signed [D_W-1:0] d;
        logic signed [D_W-1:0] s;
        d = D_W'(p >>> 22);
        s = D_W'(b) + d;
        if (s > D_W'(36'sh07FFFFFFF)) begin
            sat_add = 32'sh7FFFFFFF;
        end else if (s < -D_W'(36'sh080000000)) begin
            sat_add = 32'sh80000000;
        end else begin
            sat_add = gbg_pkg::BIAS_W'(s);
        end
    endfunction

    assign dt_s    = $signed({1'b0, r_dt});
    assign gain_s  = $signed({1'b0, i_cfg.bias_gain});
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    assign o_out.valid   = r_out_valid;
    assign o_out.bias_x  = r_out_x;
    assign o_out.bias_y  = r_out_y;
    assign o_out.updated = r_out_upd;

    // operand select for the shared multiplier
    always_comb begin
        case (r_state)
            S_P0: begin
                mul_a = MA_W'(r_ay);
                mul_b = MB_W'(r_rz);
            end
            S_P1: begin
                mul_a = MA_W'(r_az);
                mul_b = MB_W'(r_rx);
            end
            S_P2: begin
                mul_a = MA_W'(r_az);
                mul_b = MB_W'(r_ry);
            end
            S_P3: begin
                mul_a = MA_W'(r_ax);
                mul_b = MB_W'(r_rz);
            end
            S_P4: begin
                mul_a = $signed({{(MA_W-gbg_pkg::CFG_DATA_W){1'b0}}, i_cfg.limit_rate});
                mul_b = dt_s;
            end
            S_P5: begin
                mul_a = MA_W'(r_e0);
                mul_b = dt_s;
            end
            S_P6: begin
                mul_a = MA_W'(r_acc);
                mul_b = dt_s;
            end
            S_P7: begin
                mul_a = MA_W'(r_c0);
                mul_b = gain_s;
            end
            S_P8: begin
                mul_a = MA_W'(r_c1);
                mul_b = gain_s;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bias_x    <= '0;
            r_bias_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE handles the output register itself
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_upd   <= i_q_data.upd;
                        r_ax    <= i_q_data.ax;
                        r_ay    <= i_q_data.ay;
                        r_az    <= i_q_data.az;
                        r_rx    <= i_q_data.rx;
                        r_ry    <= i_q_data.ry;
                        r_rz    <= i_q_data.rz;
                        r_dt    <= i_q_data.dt;
                        r_state <= i_q_data.upd ? S_P0 : S_DONE;
                    end
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    r_acc   <= E_W'(r_prod);             // ay*rz
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_e0    <= r_acc + E_W'(r_prod);     // + az*rx
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_acc   <= -E_W'(r_prod);            // -(az*ry)
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_acc   <= r_acc - E_W'(r_prod);     // - ax*rz
                    r_state <= S_P5;
                end
                S_P5: begin
                    r_lim   <= {r_prod[31:0], 6'd0};
                    r_state <= S_P6;
                end
                S_P6: begin
                    r_c0    <= clamp(r_prod, r_lim);
                    r_state <= S_P7;
                end
                S_P7: begin
                    r_c1    <= clamp(r_prod, r_lim);
                    r_state <= S_P8;
                end
                S_P8: begin
                    r_bias_x <= sat_add(r_bias_x, r_prod);
                    r_state  <= S_P9;
                end
                S_P9: begin
                    r_bias_y <= sat_add(r_bias_y, r_prod);
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_bias_x;
                        r_out_y     <= r_bias_y;
                        r_out_upd   <= r_upd;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/gyro_bias_from_gravity.sv]
// ============================================================================
// gyro_bias_from_gravity: gyro X/Y bias estimation from the gravity vector
// Accumulates accel samples and every Nth sample corrects the gyro biases.
// ============================================================================
// Usage:
//   i_in   : one item per IMU sample (accel xyz, third matrix row, interval).
//   o_out  : exactly one item per input item, in order: current X/Y bias
//            (Q16.16) and an updated flag set on every Nth sample.
//   i_cfg_*: register writes (bias_gain, limit_rate); the user must make them
//            while idle, unenforced by the block; applied on the next clock.
// Sequencing:
//   The front end pushes each accepted item into the queue; i_in.ready
//   drops only when the two-entry queue is full.
//   Plain item: popped in S_IDLE, then S_DONE loads the output register.
//   Update item: S_P0 to S_P9 make nine passes through the one shared 41x17
//   multiplier and the bias adds; the next item is popped only in S_IDLE.
// Reset:
//   Sums, count and biases clear; gain 655 and limit rate 1331 load.
// Stall:
//   A finished item waits in the output register; the sequencer finishes
//   the next item and then holds, and the queue absorbs two more before
//   i_in.ready drops.
// ============================================================================
module gyro_bias_from_gravity #(
    parameter int SAMPLES_PER_UPDATE = gbg_pkg::SAMPLES_PER_UPDATE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gbg_in_if.sink                            i_in,
    gbg_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [gbg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gbg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    gbg_pkg::t_cfg  r_cfg;
    gbg_pkg::t_qent q_wr_data, q_rd_data;
    logic           q_push, q_pop, q_full, q_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bias_gain  <= gbg_pkg::BIAS_GAIN_RST;
            r_cfg.limit_rate <= gbg_pkg::LIMIT_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gbg_pkg::CFG_BIAS_GAIN:  r_cfg.bias_gain  <= i_cfg_data;
                gbg_pkg::CFG_LIMIT_RATE: r_cfg.limit_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accumulate and classify
    gbg_front #(
        .SAMPLES_PER_UPDATE (SAMPLES_PER_UPDATE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wr_data)
    );

    // decoupling queue
    gbg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: bias math and output register
    gbg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_data  (q_rd_data),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );
endmodule
